>>> src/itv_pkg.sv
// ----------------------------------------------------------------------------
// itv_pkg
// Types, constants and the host-name table shared by the IPv4 text validator.
// ----------------------------------------------------------------------------
package itv_pkg;

	localparam int NameLen     = 9;
	localparam int OctetMax    = 255;
	localparam int OctetSat    = 256;
	localparam int PartsNeeded = 4;
	localparam int CountSat    = 7;

	localparam logic [7:0] CharDot  = 8'h2e;
	localparam logic [7:0] CharZero = 8'h30;
	localparam logic [7:0] CharNine = 8'h39;

	// Per-string scan state
	typedef struct packed {
		logic [8:0] octet_value;
		logic [2:0] part_count;
		logic       part_nonempty;
		logic       bad_seen;
		logic [3:0] name_position;
		logic       name_matching;
	} state_t;

	localparam state_t StateReset = '{
		octet_value:   9'd0,
		part_count:    3'd0,
		part_nonempty: 1'b0,
		bad_seen:      1'b0,
		name_position: 4'd0,
		name_matching: 1'b1
	};

	// Characters of "localhost" by position
	function automatic logic [7:0] name_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = 8'h6c; // l
			4'd1:    c = 8'h6f; // o
			4'd2:    c = 8'h63; // c
			4'd3:    c = 8'h61; // a
			4'd4:    c = 8'h6c; // l
			4'd5:    c = 8'h68; // h
			4'd6:    c = 8'h6f; // o
			4'd7:    c = 8'h73; // s
			4'd8:    c = 8'h74; // t
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> src/itv_update.sv
// ----------------------------------------------------------------------------
// itv_update
// Next-state and end-of-string result logic for one character beat.
// ----------------------------------------------------------------------------
module itv_update (
	input  itv_pkg::state_t cur,
	input  logic            has_char,
	input  logic [7:0]      char_code,
	input  logic            last,
	output itv_pkg::state_t nxt,
	output logic            result
);

	always_comb begin
		itv_pkg::state_t s;
		logic [11:0] v;
		logic        is_name;
		logic        is_quad;

		s = cur;
		v = 12'd0;
		is_name = 1'b0;
		is_quad = 1'b0;

		// Take the character
		if (has_char) begin
			// Track the host-name match
			if (cur.name_matching && cur.name_position < 4'(itv_pkg::NameLen) &&
					char_code == itv_pkg::name_char(cur.name_position)) begin
				s.name_position = cur.name_position + 4'd1;
			end else begin
				s.name_matching = 1'b0;
			end

			if (char_code == itv_pkg::CharDot) begin
				// Close the current part
				if (!cur.part_nonempty || cur.octet_value > 9'(itv_pkg::OctetMax))
					s.bad_seen = 1'b1;
				if (cur.part_count < 3'(itv_pkg::CountSat))
					s.part_count = cur.part_count + 3'd1;
				s.octet_value = 9'd0;
				s.part_nonempty = 1'b0;
			end else if (char_code >= itv_pkg::CharZero && char_code <= itv_pkg::CharNine) begin
				// Accumulate a decimal digit, saturating
				v = {cur.octet_value, 3'b000} + {2'b00, cur.octet_value, 1'b0}
					+ {4'd0, char_code - itv_pkg::CharZero};
				s.octet_value = (v > 12'(itv_pkg::OctetSat)) ? 9'(itv_pkg::OctetSat) : v[8:0];
				s.part_nonempty = 1'b1;
			end else begin
				s.bad_seen = 1'b1;
			end
		end

		// Finish the string
		if (last) begin
			is_name = s.name_matching && s.name_position == 4'(itv_pkg::NameLen);
			if (s.part_nonempty) begin
				if (s.octet_value > 9'(itv_pkg::OctetMax))
					s.bad_seen = 1'b1;
				if (s.part_count < 3'(itv_pkg::CountSat))
					s.part_count = s.part_count + 3'd1;
			end
			is_quad = !s.bad_seen && s.part_count == 3'(itv_pkg::PartsNeeded);
			s = itv_pkg::StateReset;
		end

		nxt = s;
		result = is_name || is_quad;
	end

endmodule

>>> src/itv_out_reg.sv
// ----------------------------------------------------------------------------
// itv_out_reg
// Result register on the master side; holds a beat until it is taken.
// ----------------------------------------------------------------------------
module itv_out_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  logic       load_data,
	output logic       load_ready,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // [0] valid_res, [7:1] zero
);

	logic valid_q;
	logic data_q;

	assign load_ready = !valid_q || m_axis_tready;

	// Hold the result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ready && load) begin
			data_q <= load_data;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {7'd0, data_q};

endmodule

>>> src/ipv4_text_validator.sv
// ----------------------------------------------------------------------------
// ipv4_text_validator
// Checks a character stream for "localhost" or a dotted-decimal IPv4 address.
// ----------------------------------------------------------------------------
// Result path: the beat that carries tlast is held in the input register, and its result then in the result register.
// Throughput: one character beat per cycle, but a last beat stalls while the result register cannot take it.
// Reset: arst_n clears the input stage, the scan state and the result register;
// the scan state also returns to reset after each string.
module ipv4_text_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] char_code
	input  logic       s_axis_tuser,   // [0] has_char
	input  logic       s_axis_tlast,   // last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [0] valid_res, [7:1] zero
);

	logic            valid_s1;
	logic [7:0]      char_s1;
	logic            has_char_s1;
	logic            last_s1;
	itv_pkg::state_t state_q;
	itv_pkg::state_t state_nxt;
	logic            result;
	logic            out_ready;
	logic            advance;

	// Advance the input stage unless its result has nowhere to go
	assign advance       = valid_s1 && (!last_s1 || out_ready);
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1     <= s_axis_tdata;
			has_char_s1 <= s_axis_tuser;
			last_s1     <= s_axis_tlast;
		end
	end

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itv_pkg::StateReset;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	itv_update u_update (
		.cur       (state_q),
		.has_char  (has_char_s1),
		.char_code (char_s1),
		.last      (last_s1),
		.nxt       (state_nxt),
		.result    (result)
	);

	itv_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && last_s1),
		.load_data     (result),
		.load_ready    (out_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule
